[hdl/md5sh_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5sh_pkg
// shared types, constants and helpers of the md5 stream hasher
// ---------------------------------------------------------------------------
package md5sh_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned NB_W     = 3;
	localparam int unsigned DIGEST_W = 64;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS   = 64;

	localparam logic [NB_W-1:0] MAX_BYTES = 3'd4;
	localparam logic [7:0]      PAD_BYTE  = 8'h80;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [31:0] MD5_K [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_ROUND,
		ST_ADD,
		ST_PAD_MARK,
		ST_PAD_LEN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       append;
		logic       pad_mark;
		logic       pad_len;
		logic       round;
		logic [5:0] round_idx;
		logic       add;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic fills;
		logic pad_wraps;
		logic last;
		logic out_busy;
	} dp_status_t;

	// message word used by a round
	function automatic logic [3:0] msg_idx(input logic [5:0] i);
		logic [3:0] j;
		j = i[3:0];
		unique case (i[5:4])
			2'd0: msg_idx = j;
			2'd1: msg_idx = 4'((j << 2) + j + 4'd1);
			2'd2: msg_idx = 4'((j << 1) + j + 4'd5);
			default: msg_idx = 4'((j << 3) - j);
		endcase
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		rotl32 = (x << s) | (x >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

[hdl/md5sh_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5sh_ctrl
// sequencer for byte packing, padding and the 64-round compression
// ---------------------------------------------------------------------------
module md5sh_ctrl
	import md5sh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		rnd_d         = rnd_q;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.round_idx = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) state_d = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				if (status.fills) begin
					ret_d   = ST_APPEND;
					state_d = ST_ROUND;
				end else if (status.last) begin
					state_d = ST_PAD_MARK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = 6'(rnd_q + 6'd1);
				if (rnd_q == 6'(ROUNDS - 1)) state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ret_q;
			end
			ST_PAD_MARK: begin
				cmd.pad_mark = 1'b1;
				if (status.pad_wraps) begin
					ret_d   = ST_PAD_LEN;
					state_d = ST_ROUND;
				end else begin
					state_d = ST_PAD_LEN;
				end
			end
			ST_PAD_LEN: begin
				cmd.pad_len = 1'b1;
				ret_d       = ST_DONE;
				state_d     = ST_ROUND;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hdl/md5sh_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5sh_dp
// message block, round unit, chaining words and digest output buffer
// ---------------------------------------------------------------------------
module md5sh_dp
	import md5sh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	input  logic [WORD_W-1:0]   in_word,
	input  logic [NB_W-1:0]     in_nb,
	input  logic                in_last,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DIGEST_W-1:0] m_tdata,
	output logic                m_tlast
);

	logic [31:0]  blk_q [BLK_WORDS];
	logic [31:0]  rw_q [4];
	logic [31:0]  chain_q [4];
	logic [63:0]  byte_cnt_q;
	logic [31:0]  word_q;
	logic [NB_W-1:0] nb_q;
	logic         last_q;
	logic         len_be_q;
	logic [127:0] digest_q;
	logic         out_valid_q;
	logic         out_half_q;

	// append bookkeeping
	logic [5:0]      pos;
	logic [6:0]      space;
	logic [NB_W-1:0] cnt;
	logic [63:0]     bits, len;

	assign pos   = byte_cnt_q[5:0];
	assign space = 7'd64 - {1'b0, pos};
	assign cnt   = ({4'b0, nb_q} <= space) ? nb_q : space[NB_W-1:0];
	assign bits  = {byte_cnt_q[60:0], 3'b000};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			len[8*k +: 8] = len_be_q ? bits[8*(7-k) +: 8] : bits[8*k +: 8];
		end
	end

	assign status.fills     = ({4'b0, cnt} + {1'b0, pos}) == 7'd64;
	assign status.pad_wraps = pos >= 6'd56;
	assign status.last      = last_q;
	assign status.out_busy  = out_valid_q;

	// round unit
	logic [31:0] a, b, c, d, f, sum, b_new;
	logic [3:0]  g;

	always_comb begin
		if (cmd.round_idx == '0) begin
			a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
		end else begin
			a = rw_q[0]; b = rw_q[1]; c = rw_q[2]; d = rw_q[3];
		end
		unique case (cmd.round_idx[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		g     = msg_idx(cmd.round_idx);
		sum   = a + f + MD5_K[cmd.round_idx] + blk_q[g];
		b_new = b + rotl32(sum, MD5_S[{cmd.round_idx[5:4], cmd.round_idx[1:0]}]);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= in_word;
			nb_q   <= (in_nb > MAX_BYTES) ? MAX_BYTES : in_nb;
			last_q <= in_last;
		end
		if (cmd.append) begin
			word_q <= word_q >> {cnt, 3'b000};
			nb_q   <= nb_q - cnt;
		end
		if (cmd.round) begin
			rw_q[0] <= d;
			rw_q[1] <= b_new;
			rw_q[2] <= b;
			rw_q[3] <= c;
		end
		if (cmd.finish) digest_q <= {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
	end

	// block, counts and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		logic [5:0] off;
		if (!arst_n) begin
			for (int w = 0; w < BLK_WORDS; w++) blk_q[w] <= '0;
			chain_q[0]  <= IV0;
			chain_q[1]  <= IV1;
			chain_q[2]  <= IV2;
			chain_q[3]  <= IV3;
			byte_cnt_q  <= '0;
			len_be_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_half_q  <= 1'b0;
		end else begin
			if (cfg_valid) len_be_q <= cfg_data;
			if (cmd.append) begin
				for (int k = 0; k < 64; k++) begin
					off = 6'(k) - pos;
					if ({3'b0, off} < {3'b0, cnt})
						blk_q[k/4][8*(k%4) +: 8] <= word_q[8*off[1:0] +: 8];
				end
				byte_cnt_q <= byte_cnt_q + 64'(cnt);
			end
			if (cmd.pad_mark) blk_q[pos[5:2]][8*pos[1:0] +: 8] <= PAD_BYTE;
			if (cmd.pad_len) begin
				blk_q[14] <= len[31:0];
				blk_q[15] <= len[63:32];
			end
			if (cmd.add) begin
				for (int w = 0; w < 4; w++) chain_q[w] <= chain_q[w] + rw_q[w];
				for (int w = 0; w < BLK_WORDS; w++) blk_q[w] <= '0;
			end
			if (cmd.finish) begin
				chain_q[0]  <= IV0;
				chain_q[1]  <= IV1;
				chain_q[2]  <= IV2;
				chain_q[3]  <= IV3;
				byte_cnt_q  <= '0;
				out_valid_q <= 1'b1;
				out_half_q  <= 1'b0;
			end else if (out_valid_q && m_tready) begin
				if (out_half_q) out_valid_q <= 1'b0;
				out_half_q <= ~out_half_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_half_q;
	assign m_tdata  = out_half_q ? digest_q[127:64] : digest_q[63:0];

endmodule

[hdl/md5_stream_hasher.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_stream_hasher
// md5 digest over a stream of little-endian 32-bit words
// ---------------------------------------------------------------------------
// Message bytes arrive one 32-bit word per input transaction, first byte in
// bits 7..0, with 0 to 4 valid bytes (tuser, counts above 4 read as 4) and
// tlast on the final word. When tlast arrives the message is padded the
// standard md5 way and the 128-bit digest leaves as two output transactions:
// digest bytes 0..7 first, then bytes 8..15 with tlast set; the block then
// starts the next message from the md5 initial values. Each input word is
// accepted and then packed into the 64-byte block; the input is not ready
// while a word is packed, a block is compressed or a message is closed. Every
// full block passes through the single round unit for 64 rounds and then the
// chaining add. Ending a message adds the pad mark, length and digest hand-off
// steps plus one or two compressions. The digest sits in its own output
// register, so the next message is taken in while the last digest waits; only
// its end stalls until that register has drained. The configuration bit must
// be written only while no message is in flight; the block itself does not
// enforce this. When set it stores the bit count byte-swapped; it resets to standard md5 order.
// ---------------------------------------------------------------------------
module md5_stream_hasher
	import md5sh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input transactions
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,    // data_word
	input  logic [2:0]          s_tuser,    // valid_bytes
	input  logic                s_tlast,    // last_word
	// digest transactions
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,    // digest_half
	output logic                m_tlast,    // digest_last
	// length byte order register
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data    // length_big_endian
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// register write is always accepted
	assign cfg_ready = 1'b1;

	// state machine: capture, pack, pad, run rounds, hand off digest
	md5sh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// block storage, round unit and digest buffer
	md5sh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_word   (s_tdata),
		.in_nb     (s_tuser),
		.in_last   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[tb/md5_stream_hasher_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_stream_hasher_tb
// self-checking testbench for the md5 stream hasher
// ---------------------------------------------------------------------------
// A short table of messages comes first. It holds the empty message, "abc",
// byte counts of zero and above four, short words inside a message and
// all-zero and all-one words. Three random phases follow, with the length
// byte order switched between them. Many random messages end near a 64-byte
// boundary, so the extra padding block is common. A bit-accurate md5 model in
// the bench predicts both digest halves of each message whose digest the
// table lacks. Both stream sides idle at random. One phase runs with no idling
// for a while. Another opens with a long output hold-off so the input backs up.
// ---------------------------------------------------------------------------
module md5_stream_hasher_tb;

	localparam int          SETTLE_CYCLES = 150;
	localparam int          HOLD_CYCLES   = 800;
	localparam int          PHASE_WORDS   = 170;
	localparam int          IDLE_PCT      = 29;
	localparam logic [2:0]  FULL_WORD     = 3'd4;
	localparam logic [7:0]  PAD_MARK      = 8'h80;
	localparam logic [31:0] INIT_A        = 32'h67452301;
	localparam logic [31:0] INIT_B        = 32'hefcdab89;
	localparam logic [31:0] INIT_C        = 32'h98badcfe;
	localparam logic [31:0] INIT_D        = 32'h10325476;

	// well-known digests, bytes packed little-endian into each half
	localparam logic [63:0] EMPTY_LO = 64'h04b2008fd98c1dd4;
	localparam logic [63:0] EMPTY_HI = 64'h7e42f8ec980980e9;
	localparam logic [63:0] ABC_LO   = 64'hb04fd23c98500190;
	localparam logic [63:0] ABC_HI   = 64'h727fe1287d3f96d6;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [2:0]  s_tuser   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;

	md5_stream_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// md5 model state
	// ------------------------------------------------------------------
	logic [31:0] round_add [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	int unsigned rot_amt [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	logic [31:0] chain_st [4] = '{INIT_A, INIT_B, INIT_C, INIT_D};
	logic [7:0]  block_bytes [64];
	logic [63:0] msg_len  = '0;
	logic        len_swap = 1'b0;

	typedef struct {
		logic [63:0] half;
		logic        last;
	} digest_half_t;

	digest_half_t digests_due [$];

	// run bookkeeping
	int  words_sent     = 0;
	int  messages_done  = 0;
	int  late_pad_count = 0;
	int  halves_seen    = 0;
	int  fail_count     = 0;
	int  longest_stall  = 0;
	bit  calm           = 1'b0;
	bit  hold_req       = 1'b0;

	initial foreach (block_bytes[j]) block_bytes[j] = 8'h00;

	function automatic void compress_block_bytes();
		logic [31:0] a, b, c, d, f, t, m;
		int unsigned g, ph, r;
		a = chain_st[0];
		b = chain_st[1];
		c = chain_st[2];
		d = chain_st[3];
		for (int i = 0; i < 64; i++) begin
			ph = i / 16;
			case (ph)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			m = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
			r = rot_amt[ph * 4 + i % 4];
			t = a + f + round_add[i] + m;
			t = (t << r) | (t >> (32 - r));
			a = d;
			d = c;
			c = b;
			b = b + t;
		end
		chain_st[0] += a;
		chain_st[1] += b;
		chain_st[2] += c;
		chain_st[3] += d;
		foreach (block_bytes[j]) block_bytes[j] = 8'h00;
	endfunction

	function automatic void take_byte(input logic [7:0] v);
		block_bytes[msg_len[5:0]] = v;
		msg_len++;
		if (msg_len[5:0] == 6'd0)
			compress_block_bytes();
	endfunction

	// absorbs one input word; returns 1 with both digest halves when it ends a message
	function automatic bit absorb_word(input logic [31:0] data, input logic [2:0] nb,
			input logic last, output logic [63:0] lo, output logic [63:0] hi);
		int          n;
		int unsigned pos;
		logic [63:0] bits;
		lo = '0;
		hi = '0;
		n = (nb > FULL_WORD) ? 4 : int'(nb);
		for (int i = 0; i < n; i++)
			take_byte(data[8*i +: 8]);
		if (!last)
			return 1'b0;
		bits = msg_len << 3;
		pos = msg_len[5:0];
		block_bytes[pos] = PAD_MARK;
		// no room left for the length: close this block and pad a fresh one
		if (pos >= 56) begin
			compress_block_bytes();
			late_pad_count++;
		end
		for (int i = 0; i < 8; i++)
			block_bytes[56+i] = len_swap ? bits[8*(7-i) +: 8] : bits[8*i +: 8];
		compress_block_bytes();
		lo = {chain_st[1], chain_st[0]};
		hi = {chain_st[3], chain_st[2]};
		chain_st = '{INIT_A, INIT_B, INIT_C, INIT_D};
		msg_len = '0;
		messages_done++;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nb;
		logic        last;
		logic        typed;
		logic [63:0] lo;
		logic [63:0] hi;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 14;

	stim_row_t directed [DIRECTED_ROWS] = '{
		// empty message, junk in an unused word
		'{32'hffffffff, 3'd0, 1'b1, 1'b1, EMPTY_LO, EMPTY_HI},
		// "abc", top byte must be ignored
		'{32'hff636261, 3'd3, 1'b1, 1'b1, ABC_LO, ABC_HI},
		// byte counts above four saturate
		'{32'h00000000, 3'd7, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'hffffffff, 3'd5, 1'b1, 1'b0, 64'h0, 64'h0},
		// short words inside a message keep packing bytes
		'{32'h000000a5, 3'd1, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'h0000c3b2, 3'd2, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'h00f0e1d2, 3'd3, 1'b0, 1'b0, 64'h0, 64'h0},
		// zero bytes mid-message adds nothing
		'{32'hdeadbeef, 3'd0, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'h01234567, 3'd4, 1'b1, 1'b0, 64'h0, 64'h0},
		'{32'h80000001, 3'd4, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'h7ffffffe, 3'd6, 1'b1, 1'b0, 64'h0, 64'h0},
		'{32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_LO, EMPTY_HI},
		'{32'hffffffff, 3'd4, 1'b0, 1'b0, 64'h0, 64'h0},
		'{32'hffffffff, 3'd4, 1'b1, 1'b0, 64'h0, 64'h0}
	};

	task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic last,
			input logic typed, input logic [63:0] typed_lo, input logic [63:0] typed_hi);
		logic [63:0]  lo, hi;
		int           stall;
		digest_half_t e;
		stall = 0;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= nb;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			stall++;
			@(posedge clk);
		end
		if (stall > longest_stall)
			longest_stall = stall;
		words_sent++;
		if (absorb_word(data, nb, last, lo, hi)) begin
			e.half = typed ? typed_lo : lo;
			e.last = 1'b0;
			digests_due.push_back(e);
			e.half = typed ? typed_hi : hi;
			e.last = 1'b1;
			digests_due.push_back(e);
		end
	endtask

	// lengths cluster around one block so the late-padding path is common
	task automatic send_random_message();
		int          nw, pick;
		logic [31:0] w;
		logic [2:0]  nb;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			nw = $urandom_range(1, 4);
		else if (pick < 55)
			nw = $urandom_range(5, 12);
		else if (pick < 85)
			nw = $urandom_range(13, 18);
		else
			nw = $urandom_range(19, 40);
		for (int k = 0; k < nw; k++) begin
			pick = $urandom_range(0, 9);
			w = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffffffff : 32'($urandom);
			if (k == nw - 1 || $urandom_range(0, 9) == 0)
				nb = 3'($urandom_range(0, 7));
			else
				nb = FULL_WORD;
			send_word(w, nb, k == nw - 1, 1'b0, 64'h0, 64'h0);
		end
	endtask

	// register write, only once every digest is out and the block has gone quiet
	task automatic write_len_order(input logic v);
		s_tvalid <= 1'b0;
		while (digests_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		len_swap = v;
	endtask

	initial begin
		int phase_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_len_order(1'b0);
		foreach (directed[r])
			send_word(directed[r].data, directed[r].nb, directed[r].last,
				directed[r].typed, directed[r].lo, directed[r].hi);
		for (int ph = 1; ph <= 3; ph++) begin
			write_len_order(ph != 2);
			phase_start = words_sent;
			// output side stalls for a long stretch while input keeps coming
			if (ph == 3)
				hold_req = 1'b1;
			while (words_sent - phase_start < PHASE_WORDS) begin
				calm = (ph == 2) && (words_sent - phase_start < PHASE_WORDS / 2);
				send_random_message();
			end
			calm = 1'b0;
		end
		s_tvalid <= 1'b0;
		while (digests_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d messages from %0d input words, %0d digest halves compared",
			messages_done, words_sent, halves_seen);
		$display("%0d messages needed an extra padding block, longest input stall %0d cycles",
			late_pad_count, longest_stall);
		if (fail_count == 0)
			$display("md5_stream_hasher_tb: clean");
		else
			$display("md5_stream_hasher_tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// digest receiver and checker
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_digest
		digest_half_t want;
		if (m_tvalid && m_tready) begin
			halves_seen++;
			if (digests_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: digest transaction %h last %b with none expected",
						$realtime, m_tdata, m_tlast);
			end else begin
				want = digests_due.pop_front();
				if (m_tdata !== want.half || m_tlast !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: digest half expected %h last %b, got %h last %b",
							$realtime, want.half, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("md5_stream_hasher_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
hdl/md5sh_pkg.sv
hdl/md5sh_ctrl.sv
hdl/md5sh_dp.sv
hdl/md5_stream_hasher.sv
tb/md5_stream_hasher_tb.sv
